@@ sv/xtea2_pkg.sv @@
// Shared types, constants and helper functions for the two-block XTEA cipher.
// Used by the cipher's top level and half-round module; depends on nothing.
package xtea2_pkg;

	localparam int unsigned ROUNDS_DEFAULT = 32;
	localparam logic [31:0] XT_DELTA = 32'h9E37_79B9;
	localparam int unsigned KEY_COUNT = 4;
	localparam int unsigned KEY_IDX_W = 2;

	localparam logic [KEY_IDX_W-1:0] REG_KEY_0 = 2'd0;
	localparam logic [KEY_IDX_W-1:0] REG_KEY_1 = 2'd1;
	localparam logic [KEY_IDX_W-1:0] REG_KEY_2 = 2'd2;
	localparam logic [KEY_IDX_W-1:0] REG_KEY_3 = 2'd3;

	typedef logic [KEY_COUNT-1:0][31:0] key_set_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] y0;
		logic [31:0] z0;
		logic [31:0] y1;
		logic [31:0] z1;
	} blk_state_t;

	function automatic logic [31:0] mix(input logic [31:0] x);
		mix = ((x << 4) ^ (x >> 5)) + x;
	endfunction

	// Round sum after n delta steps, modulo 2^32.
	function automatic logic [31:0] sum_at(input int unsigned n);
		logic [63:0] prod;
		prod = 64'(XT_DELTA) * 64'(n);
		sum_at = prod[31:0];
	endfunction

endpackage

@@ sv/xtea2_half_round.sv @@
// One registered Feistel half-round applied to both XTEA blocks of a word.
// Depends on xtea2_pkg for the state type, key set type and mix function.
module xtea2_half_round #(
	parameter logic [31:0] SUM_ENC = 32'h0,
	parameter logic [31:0] SUM_DEC = 32'h0,
	parameter bit          HALF    = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xtea2_pkg::key_set_t   keys,
	input  logic                  take,
	input  logic                  up_valid,
	input  xtea2_pkg::blk_state_t up_data,
	output logic                  valid_s1,
	output xtea2_pkg::blk_state_t data_s1
);

	localparam logic [1:0] KEY_ENC = HALF ? SUM_ENC[12:11] : SUM_ENC[1:0];
	localparam logic [1:0] KEY_DEC = HALF ? SUM_DEC[1:0] : SUM_DEC[12:11];

	logic [31:0]           t;
	logic                  upd_y;
	logic [31:0]           f0;
	logic [31:0]           f1;
	logic [31:0]           d0;
	logic [31:0]           d1;
	logic [31:0]           n0;
	logic [31:0]           n1;
	xtea2_pkg::blk_state_t nxt;

	always_comb begin
		t = up_data.mode ? (SUM_ENC + keys[KEY_ENC]) : (SUM_DEC + keys[KEY_DEC]);
		upd_y = up_data.mode ^ HALF;
		f0 = xtea2_pkg::mix(upd_y ? up_data.z0 : up_data.y0) ^ t;
		f1 = xtea2_pkg::mix(upd_y ? up_data.z1 : up_data.y1) ^ t;
		d0 = upd_y ? up_data.y0 : up_data.z0;
		d1 = upd_y ? up_data.y1 : up_data.z1;
		n0 = up_data.mode ? (d0 + f0) : (d0 - f0);
		n1 = up_data.mode ? (d1 + f1) : (d1 - f1);
		nxt = up_data;
		if (upd_y) begin
			nxt.y0 = n0;
			nxt.y1 = n1;
		end else begin
			nxt.z0 = n0;
			nxt.z1 = n1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && up_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

@@ sv/xtea_cipher_two_block.sv @@
// Throughput: one word per cycle while the output is not stalled; each stage holds one half-round for both blocks.
// A stage moves when it is empty or the stage after it moves, so bubbles close up.
// Reset clears the key registers to zero and all stage valid bits at once.
// Top level of the two-block XTEA cipher; instantiates xtea2_half_round.
// Depends on xtea2_pkg.
module xtea_cipher_two_block #(
	parameter int unsigned ROUNDS = xtea2_pkg::ROUNDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xtea2_pkg::KEY_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [31:0]                     text_w0,
	input  logic [31:0]                     text_w1,
	input  logic [31:0]                     text_w2,
	input  logic [31:0]                     text_w3,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     result_w0,
	output logic [31:0]                     result_w1,
	output logic [31:0]                     result_w2,
	output logic [31:0]                     result_w3
);

	localparam int unsigned STAGES = 2 * ROUNDS;

	xtea2_pkg::key_set_t   key_q;
	logic                  vld [STAGES+1];
	xtea2_pkg::blk_state_t dat [STAGES+1];
	logic                  take [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				xtea2_pkg::REG_KEY_0: key_q[0] <= cfg_data;
				xtea2_pkg::REG_KEY_1: key_q[1] <= cfg_data;
				xtea2_pkg::REG_KEY_2: key_q[2] <= cfg_data;
				xtea2_pkg::REG_KEY_3: key_q[3] <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	assign vld[0] = in_valid;
	assign dat[0] = '{mode: mode, y0: text_w3, z0: text_w2, y1: text_w1, z1: text_w0};
	assign take[STAGES] = !vld[STAGES] || !out_stall;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam int unsigned RND = k / 2;
		localparam bit HALF = (k % 2) == 1;
		localparam logic [31:0] SE = xtea2_pkg::sum_at(RND + (HALF ? 1 : 0));
		localparam logic [31:0] SD = xtea2_pkg::sum_at(ROUNDS - RND - (HALF ? 1 : 0));

		assign take[k] = !vld[k+1] || take[k+1];

		xtea2_half_round #(
			.SUM_ENC (SE),
			.SUM_DEC (SD),
			.HALF    (HALF)
		) u_half (
			.clk      (clk),
			.arst_n   (arst_n),
			.keys     (key_q),
			.take     (take[k]),
			.up_valid (vld[k]),
			.up_data  (dat[k]),
			.valid_s1 (vld[k+1]),
			.data_s1  (dat[k+1])
		);
	end

	assign in_stall  = !take[0];
	assign out_valid = vld[STAGES];
	assign result_w0 = dat[STAGES].z1;
	assign result_w1 = dat[STAGES].y1;
	assign result_w2 = dat[STAGES].z0;
	assign result_w3 = dat[STAGES].y0;

endmodule

@@ sv/xtea2_checker.sv @@
// Port-level checks for the two-block XTEA cipher, bound to its top level.
// Depends only on the top level's ports.
module xtea2_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result_w0,
	input logic [31:0] result_w1,
	input logic [31:0] result_w2,
	input logic [31:0] result_w3
);

	// The input side only waits when the output word is held back.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output is free");

	// An empty output stage means nothing can block the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output word dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(result_w0) && $stable(result_w1)
			&& $stable(result_w2) && $stable(result_w3)))
		else $error("stalled output word changed");

endmodule

bind xtea_cipher_two_block xtea2_checker u_xtea2_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result_w0 (result_w0),
	.result_w1 (result_w1),
	.result_w2 (result_w2),
	.result_w3 (result_w3)
);
